### hw/rtl/assert_macros.svh
// Assertion helpers used by the scheduler top level. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/dps_pkg.sv
package dps_pkg;

    localparam int DPS_SLOTS = 16;

    localparam logic [7:0] BASE_PRIORITY_RST = 8'd50;
    localparam logic [3:0] PRIORITY_STEP_RST = 4'd3;

    // configuration register indexes
    localparam logic REG_BASE_PRIORITY = 1'b0;
    localparam logic REG_PRIORITY_STEP = 1'b1;

    // input commands
    localparam logic CMD_CREATE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_REJECT    = 2'd1;
    localparam logic [1:0] STAT_IDLE      = 2'd2;
    localparam logic [1:0] STAT_ZERO_NEED = 2'd3;

    localparam logic signed [11:0] PRIO_MIN = 12'sh800;

    // one process context, as held in the ready queue and the running register
    typedef struct packed {
        logic [3:0]         id;
        logic signed [11:0] prio;
        logic [7:0]         rem;
        logic [7:0]         cpu;
    } dps_entry_t;

    typedef struct packed {
        logic       latch_in;       // capture input item, clear per-item flags
        logic       setup_create;   // build new entry, mark slot busy, start insert
        logic       rd_head;        // queue read address = head
        logic       load_head;      // running <= head entry, pop queue
        logic       update_run;     // charge one tick to running process
        logic       finish_run;     // retire running process
        logic       preempt;        // requeue running process, start insert
        logic       ins_write_cand; // place insert candidate, count++
        logic       ins_shift;      // move entry one place toward tail
        logic       set_status;
        logic [1:0] status_code;
        logic       report;         // register result, raise done
    } dps_ctl_t;

    typedef struct packed {
        logic cmd_tick;
        logic need_zero;
        logic reject;
        logic running;
        logic queue_empty;
        logic run_done;
        logic pre_win;
        logic ins_left_zero;
        logic ins_stop;
    } dps_sts_t;

endpackage

### hw/rtl/dps_ram.sv
module dps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/dps_ctrl.sv
module dps_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dps_pkg::dps_sts_t  sts,
    output dps_pkg::dps_ctl_t  ctl
);
    import dps_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_UPDATE   = 4'd3;
    localparam logic [3:0] S_POST     = 4'd4;
    localparam logic [3:0] S_REFILL   = 4'd5;
    localparam logic [3:0] S_PRE_CHK  = 4'd6;
    localparam logic [3:0] S_INS_CHK  = 4'd7;
    localparam logic [3:0] S_INS_CMP  = 4'd8;
    localparam logic [3:0] S_REPORT   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!sts.cmd_tick)
                begin
                    if (sts.need_zero)
                    begin
                        ctl.set_status  = 1'b1;
                        ctl.status_code = STAT_ZERO_NEED;
                        state_next      = S_REPORT;
                    end
                    else if (sts.reject)
                    begin
                        ctl.set_status  = 1'b1;
                        ctl.status_code = STAT_REJECT;
                        state_next      = S_REPORT;
                    end
                    else
                    begin
                        ctl.setup_create = 1'b1;
                        state_next       = S_INS_CHK;
                    end
                end
                else if (sts.running)
                begin
                    state_next = S_UPDATE;
                end
                else if (sts.queue_empty)
                begin
                    ctl.set_status  = 1'b1;
                    ctl.status_code = STAT_IDLE;
                    state_next      = S_REPORT;
                end
                else
                begin
                    ctl.rd_head = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                ctl.load_head = 1'b1;
                state_next    = S_UPDATE;
            end
            S_UPDATE:
            begin
                ctl.update_run = 1'b1;
                state_next     = S_POST;
            end
            S_POST:
            begin
                if (sts.run_done)
                begin
                    ctl.finish_run = 1'b1;
                    ctl.rd_head    = 1'b1;
                    state_next     = sts.queue_empty ? S_REPORT : S_REFILL;
                end
                else
                begin
                    ctl.rd_head = 1'b1;
                    state_next  = sts.queue_empty ? S_REPORT : S_PRE_CHK;
                end
            end
            S_REFILL:
            begin
                ctl.load_head = 1'b1;
                state_next    = S_REPORT;
            end
            S_PRE_CHK:
            begin
                // head strictly outranks the running process
                if (sts.pre_win)
                begin
                    ctl.preempt   = 1'b1;
                    ctl.load_head = 1'b1;
                    state_next    = S_INS_CHK;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end
            S_INS_CHK:
            begin
                if (sts.ins_left_zero)
                begin
                    ctl.ins_write_cand = 1'b1;
                    state_next         = S_REPORT;
                end
                else
                begin
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (sts.ins_stop)
                begin
                    ctl.ins_write_cand = 1'b1;
                    state_next         = S_REPORT;
                end
                else
                begin
                    ctl.ins_shift = 1'b1;
                    state_next    = S_INS_CHK;
                end
            end
            S_REPORT:
            begin
                ctl.report = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/dps_datapath.sv
module dps_datapath #(
    parameter int SLOTS = dps_pkg::DPS_SLOTS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd,
    input  logic [3:0]          proc_id,
    input  logic [7:0]          need_time,
    input  logic                cfg_valid,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data,
    input  dps_pkg::dps_ctl_t   ctl,
    output dps_pkg::dps_sts_t   sts,
    output logic                done,
    output logic [1:0]          status,
    output logic                running_valid,
    output logic [3:0]          running_id,
    output logic signed [11:0]  running_priority,
    output logic [7:0]          running_remaining,
    output logic [7:0]          running_cpu_time,
    output logic                finished_valid,
    output logic [3:0]          finished_id,
    output logic                preempted
);
    import dps_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = SLOT_W + 2;
    localparam int ENT_W  = $bits(dps_entry_t);

    logic [7:0]        base_prio_reg;
    logic [3:0]        step_reg;

    logic              cmd_reg;
    logic [3:0]        id_reg;
    logic [7:0]        need_reg;

    logic [SLOTS-1:0]  busy_reg;
    logic [SLOT_W-1:0] head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SLOT_W-1:0] ptr_reg;
    logic [CNT_W-1:0]  left_reg;

    logic              run_flag_reg;
    dps_entry_t        run_reg;
    dps_entry_t        cand_reg;

    logic [1:0]        stat_reg;
    logic              fin_valid_reg;
    logic [3:0]        fin_id_reg;
    logic              pre_reg;

    logic              done_reg;
    logic [1:0]        status_reg;
    logic              run_valid_out_reg;
    dps_entry_t        run_out_reg;
    logic              fin_valid_out_reg;
    logic [3:0]        fin_id_out_reg;
    logic              pre_out_reg;

    logic [ENT_W-1:0]  ram_rdata;
    logic [ENT_W-1:0]  ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic              ram_we;
    dps_entry_t        head_ent;
    dps_entry_t        create_ent;

    logic [SLOT_W-1:0] id_slot;
    logic              id_out_range;
    logic              queue_full;
    logic [SUM_W-1:0]  tail_sum;
    logic [SLOT_W-1:0] tail;
    logic [SLOT_W-1:0] head_inc;
    logic [SLOT_W-1:0] ptr_prev;
    logic [12:0]       prio_dec;
    logic [11:0]       prio_next;
    logic [7:0]        cpu_next;
    logic [7:0]        rem_next;

    assign head_ent = ram_rdata;

    assign id_slot      = SLOT_W'(id_reg);
    assign id_out_range = ({5'd0, id_reg} >= 9'(SLOTS));
    assign queue_full   = (count_reg == CNT_W'(SLOTS));

    // ring buffer: logical entry i sits at (head + i) mod SLOTS
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= SUM_W'(SLOTS)) ? SLOT_W'(tail_sum - SUM_W'(SLOTS))
                                                  : SLOT_W'(tail_sum);
    assign head_inc = (head_reg == SLOT_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;
    assign ptr_prev = (ptr_reg == '0) ? SLOT_W'(SLOTS - 1) : ptr_reg - 1'b1;

    // priority drop with floor at the most negative code
    assign prio_dec  = {run_reg.prio[11], run_reg.prio} - {9'd0, step_reg};
    assign prio_next = (prio_dec[12] && !prio_dec[11]) ? PRIO_MIN : prio_dec[11:0];
    assign cpu_next  = (run_reg.cpu == 8'hFF) ? 8'hFF : run_reg.cpu + 8'd1;
    assign rem_next  = (run_reg.rem == 8'd0) ? 8'd0 : run_reg.rem - 8'd1;

    always_comb
    begin
        create_ent.id   = id_reg;
        create_ent.prio = 12'({4'd0, base_prio_reg}) - 12'({4'd0, need_reg});
        create_ent.rem  = need_reg;
        create_ent.cpu  = 8'd0;
    end

    assign ram_raddr = ctl.rd_head ? head_reg : ptr_prev;
    assign ram_we    = ctl.ins_write_cand | ctl.ins_shift;
    assign ram_wdata = ctl.ins_write_cand ? cand_reg : head_ent;

    dps_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        sts.cmd_tick      = (cmd_reg == CMD_TICK);
        sts.need_zero     = (need_reg == 8'd0);
        sts.reject        = id_out_range || busy_reg[id_slot] || queue_full;
        sts.running       = run_flag_reg;
        sts.queue_empty   = (count_reg == '0);
        sts.run_done      = (run_reg.rem == 8'd0);
        sts.pre_win       = ($signed(run_reg.prio) < $signed(head_ent.prio));
        sts.ins_left_zero = (left_reg == '0);
        sts.ins_stop      = ($signed(head_ent.prio) >= $signed(cand_reg.prio));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_prio_reg <= BASE_PRIORITY_RST;
            step_reg      <= PRIORITY_STEP_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BASE_PRIORITY: base_prio_reg <= cfg_data;
                REG_PRIORITY_STEP: step_reg      <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    // input item capture
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            cmd_reg  <= cmd;
            id_reg   <= proc_id;
            need_reg <= need_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            head_reg      <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            left_reg      <= '0;
            run_flag_reg  <= 1'b0;
            stat_reg      <= STAT_OK;
            fin_valid_reg <= 1'b0;
            fin_id_reg    <= 4'd0;
            pre_reg       <= 1'b0;
        end
        else
        begin
            if (ctl.latch_in)
            begin
                stat_reg      <= STAT_OK;
                fin_valid_reg <= 1'b0;
                fin_id_reg    <= 4'd0;
                pre_reg       <= 1'b0;
            end
            if (ctl.set_status)
            begin
                stat_reg <= ctl.status_code;
            end

            if (ctl.setup_create)
            begin
                busy_reg[id_slot] <= 1'b1;
            end
            else if (ctl.finish_run)
            begin
                busy_reg[SLOT_W'(run_reg.id)] <= 1'b0;
            end

            if (ctl.load_head)
            begin
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end
            else if (ctl.ins_write_cand)
            begin
                count_reg <= count_reg + 1'b1;
            end

            // insert walks back from the tail; pop in the same cycle keeps the tail
            if (ctl.setup_create || ctl.preempt)
            begin
                ptr_reg  <= tail;
                left_reg <= count_reg - CNT_W'(ctl.load_head);
            end
            else if (ctl.ins_shift)
            begin
                ptr_reg  <= ptr_prev;
                left_reg <= left_reg - 1'b1;
            end

            if (ctl.load_head)
            begin
                run_flag_reg <= 1'b1;
            end
            else if (ctl.finish_run)
            begin
                run_flag_reg  <= 1'b0;
                fin_valid_reg <= 1'b1;
                fin_id_reg    <= run_reg.id;
            end

            if (ctl.preempt)
            begin
                pre_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_head)
        begin
            run_reg <= head_ent;
        end
        else if (ctl.update_run)
        begin
            run_reg.prio <= prio_next;
            run_reg.rem  <= rem_next;
            run_reg.cpu  <= cpu_next;
        end

        if (ctl.setup_create)
        begin
            cand_reg <= create_ent;
        end
        else if (ctl.preempt)
        begin
            cand_reg <= run_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg          <= 1'b0;
            status_reg        <= STAT_OK;
            run_valid_out_reg <= 1'b0;
            run_out_reg       <= '0;
            fin_valid_out_reg <= 1'b0;
            fin_id_out_reg    <= 4'd0;
            pre_out_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.report;
            if (ctl.report)
            begin
                status_reg        <= stat_reg;
                run_valid_out_reg <= run_flag_reg;
                run_out_reg       <= run_flag_reg ? run_reg : '0;
                fin_valid_out_reg <= fin_valid_reg;
                fin_id_out_reg    <= fin_id_reg;
                pre_out_reg       <= pre_reg;
            end
        end
    end

    assign done              = done_reg;
    assign status            = status_reg;
    assign running_valid     = run_valid_out_reg;
    assign running_id        = run_out_reg.id;
    assign running_priority  = run_out_reg.prio;
    assign running_remaining = run_out_reg.rem;
    assign running_cpu_time  = run_out_reg.cpu;
    assign finished_valid    = fin_valid_out_reg;
    assign finished_id       = fin_id_out_reg;
    assign preempted         = pre_out_reg;

endmodule

### hw/rtl/dynamic_priority_scheduler_unit.sv
// Preemptive dynamic-priority scheduler.
// Command channel: drive cmd/proc_id/need_time with start; the item transfers on
// a clock edge where start is high and busy is low. cmd selects create or tick.
// Result channel: done pulses high for one cycle with status, the running
// process snapshot, finished_valid/finished_id and preempted. The receiver
// cannot stall; fields hold until the next result.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0 is base priority, index 1 the per-tick priority step.
// A refused create or idle tick goes from decode straight to report; the
// longest tick without requeue passes dispatch, update, finish and refill.
// A sorted insert (create or preemption) adds a check and compare per queue
// entry moved; the longest item is a dispatch followed by a preemption that
// moves SLOTS-2 entries. One item at a time; the insert walk moves one entry
// per check and compare through the single read port of the ready-queue RAM.
// Reset empties the queue, frees all ids, stops the running process and
// restores base priority 50 and step 3. No clearing pass is needed.
`include "assert_macros.svh"

module dynamic_priority_scheduler_unit #(
    parameter int SLOTS = dps_pkg::DPS_SLOTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [3:0]         proc_id,
    input  logic [7:0]         need_time,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data,
    output logic               done,
    output logic [1:0]         status,
    output logic               running_valid,
    output logic [3:0]         running_id,
    output logic signed [11:0] running_priority,
    output logic [7:0]         running_remaining,
    output logic [7:0]         running_cpu_time,
    output logic               finished_valid,
    output logic [3:0]         finished_id,
    output logic               preempted
);
    import dps_pkg::*;

    dps_ctl_t ctl;
    dps_sts_t sts;

    assign cfg_ready = 1'b1;

    dps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .ctl   (ctl)
    );

    dps_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .proc_id           (proc_id),
        .need_time         (need_time),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .ctl               (ctl),
        .sts               (sts),
        .done              (done),
        .status            (status),
        .running_valid     (running_valid),
        .running_id        (running_id),
        .running_priority  (running_priority),
        .running_remaining (running_remaining),
        .running_cpu_time  (running_cpu_time),
        .finished_valid    (finished_valid),
        .finished_id       (finished_id),
        .preempted         (preempted)
    );

    `ASSERT_SAME_CYCLE(a_done_when_free, clk, rst_n, done, !busy)
    `ASSERT_NEXT_CYCLE(a_start_takes_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_NEXT_CYCLE(a_done_single, clk, rst_n, done, !done)
    `ASSERT_SAME_CYCLE(a_fin_excl_preempt, clk, rst_n, done && finished_valid,
                       !preempted)
    `ASSERT_SAME_CYCLE(a_idle_tick_empty, clk, rst_n, done && status == STAT_IDLE,
                       !running_valid && !finished_valid)

endmodule
